>>> rtl/core/bdm_pkg.sv
// Shared types, constants and interpolation functions of the Bayer demosaic block.
package bdm_pkg;

  localparam int MaxQuadColumns = 2048;
  localparam int ColW           = $clog2(MaxQuadColumns);
  localparam int CfgW           = 12;
  localparam int RowW           = 16;
  localparam int SampleW        = 15;
  localparam int PixW           = 16;

  localparam logic [CfgW-1:0] MinWidth = CfgW'(3);
  localparam logic [CfgW-1:0] MaxWidth = CfgW'(MaxQuadColumns);

  // window offsets: minus one, centre, plus one
  localparam logic [1:0] OffM = 2'd0;
  localparam logic [1:0] OffZ = 2'd1;
  localparam logic [1:0] OffP = 2'd2;

  typedef struct packed {
    logic [SampleW-1:0] gr;
    logic [SampleW-1:0] r;
    logic [SampleW-1:0] b;
    logic [SampleW-1:0] gb;
  } quad_t;

  // line store entry: quad two rows up and quad one row up
  typedef struct packed {
    quad_t older;
    quad_t prior;
  } row_pair_t;

  // indexed [column][row]
  typedef quad_t [2:0][2:0] win_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

  // centred window handed from the front end to the interpolation stage
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    win_t            win;
  } win_req_t;

  function automatic logic [SampleW-1:0] avg2(logic [SampleW-1:0] a, logic [SampleW-1:0] b);
    logic [SampleW:0] s;
    s = {1'b0, a} + {1'b0, b} + (SampleW+1)'(1);
    return s[SampleW:1];
  endfunction

  function automatic logic [SampleW-1:0] absd(logic [SampleW-1:0] a, logic [SampleW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SampleW-1:0] green_at_red(win_t w, logic [1:0] ci, logic [1:0] rj);
    logic [SampleW-1:0] gv, gh, gvd, ghd;
    gv  = avg2(w[ci][rj - 2'd1].gb, w[ci][rj].gb);
    gvd = absd(w[ci][rj - 2'd1].gb, w[ci][rj].gb);
    gh  = avg2(w[ci + 2'd1][rj].gr, w[ci][rj].gr);
    ghd = absd(w[ci + 2'd1][rj].gr, w[ci][rj].gr);
    return (ghd < gvd) ? gh : gv;
  endfunction

  function automatic logic [SampleW-1:0] green_at_blue(win_t w, logic [1:0] ci, logic [1:0] rj);
    logic [SampleW-1:0] gv, gh, gvd, ghd;
    gv  = avg2(w[ci][rj + 2'd1].gr, w[ci][rj].gr);
    gvd = absd(w[ci][rj + 2'd1].gr, w[ci][rj].gr);
    gh  = avg2(w[ci - 2'd1][rj].gb, w[ci][rj].gb);
    ghd = absd(w[ci - 2'd1][rj].gb, w[ci][rj].gb);
    return (ghd < gvd) ? gh : gv;
  endfunction

  // green-corrected colour average, wrapping to the output width
  function automatic logic [PixW-1:0] corrected(logic [SampleW-1:0] g, logic [SampleW-1:0] ga,
                                                logic [SampleW-1:0] gb, logic [SampleW-1:0] ca,
                                                logic [SampleW-1:0] cb);
    return {1'b0, g} - {1'b0, avg2(ga, gb)} + {1'b0, avg2(ca, cb)};
  endfunction

endpackage

>>> rtl/core/bdm_line_ram.sv
// Generic single-write, single-read line memory with registered read data.
module bdm_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 120
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/bdm_front.sv
// Front end: width register, position counters, line store and the 3x3 quad window.
module bdm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bdm_pkg::CfgW-1:0]   cfg_quad_columns_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bdm_pkg::quad_t             quad_i,
  input  logic                       frame_start_i,
  output bdm_pkg::win_req_t          req_o,
  input  logic                       req_ready_i
);

  logic [bdm_pkg::CfgW-1:0] width_q, eff_width;
  logic [bdm_pkg::ColW-1:0] col_q, col_d, cur_col;
  logic [bdm_pkg::RowW-1:0] row_q, row_d, cur_row;
  logic [bdm_pkg::CfgW-1:0] col_next;
  logic                     accept;

  logic                     s1_valid_q;
  bdm_pkg::quad_t           s1_quad_q;
  logic [bdm_pkg::ColW-1:0] s1_col_q;
  logic [bdm_pkg::RowW-1:0] s1_row_q;
  logic                     s1_fwd_q;
  bdm_pkg::row_pair_t       s1_fwd_data_q;
  logic                     s1_emit, s1_go;

  bdm_pkg::row_pair_t       rd_data, entry, wr_data;
  bdm_pkg::quad_t           wc_q [6];

  assign cfg_ready_o = 1'b1;

  // hold the width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= bdm_pkg::MaxWidth;
    end else if (cfg_valid_i) begin
      width_q <= cfg_quad_columns_i;
    end
  end

  always_comb begin
    if (width_q < bdm_pkg::MinWidth) begin
      eff_width = bdm_pkg::MinWidth;
    end else if (width_q > bdm_pkg::MaxWidth) begin
      eff_width = bdm_pkg::MaxWidth;
    end else begin
      eff_width = width_q;
    end
  end

  // position of the arriving quad
  assign cur_col  = frame_start_i ? '0 : col_q;
  assign cur_row  = frame_start_i ? '0 : row_q;
  assign col_next = {1'b0, cur_col} + bdm_pkg::CfgW'(1);
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    if (col_next >= eff_width) begin
      col_d = '0;
      row_d = cur_row + bdm_pkg::RowW'(1);
    end else begin
      col_d = col_next[bdm_pkg::ColW-1:0];
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store entry, with the pending write forwarded
  assign entry   = s1_fwd_q ? s1_fwd_data_q : rd_data;
  assign wr_data = '{older: entry.prior, prior: s1_quad_q};
  assign s1_emit = (s1_col_q >= bdm_pkg::ColW'(2)) && (s1_row_q >= bdm_pkg::RowW'(2));
  assign s1_go   = s1_valid_q && (!s1_emit || req_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  bdm_line_ram #(
    .DEPTH (bdm_pkg::MaxQuadColumns),
    .WIDTH ($bits(bdm_pkg::row_pair_t))
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (cur_col),
    .rd_data_o (rd_data)
  );

  // advance the store stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_quad_q     <= quad_i;
      s1_col_q      <= cur_col;
      s1_row_q      <= cur_row;
      s1_fwd_q      <= s1_go && (s1_col_q == cur_col);
      s1_fwd_data_q <= wr_data;
    end
  end

  // shift the window columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        wc_q[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 3; k++) begin
        wc_q[k] <= wc_q[k+3];
      end
      wc_q[3] <= entry.older;
      wc_q[4] <= entry.prior;
      wc_q[5] <= s1_quad_q;
    end
  end

  always_comb begin
    req_o.valid = s1_valid_q && s1_emit;
    req_o.col   = s1_col_q - bdm_pkg::ColW'(1);
    req_o.row   = s1_row_q - bdm_pkg::RowW'(1);
    for (int k = 0; k < 3; k++) begin
      req_o.win[0][k] = wc_q[k];
      req_o.win[1][k] = wc_q[k+3];
    end
    req_o.win[2][0] = entry.older;
    req_o.win[2][1] = entry.prior;
    req_o.win[2][2] = s1_quad_q;
  end

endmodule

>>> rtl/core/bdm_interp.sv
// Edge-directed interpolation of the four pixels of the centred quad.
module bdm_interp (
  input  bdm_pkg::win_t            win_i,
  output bdm_pkg::pixel_t [3:0]    px_o
);

  localparam logic [1:0] M = bdm_pkg::OffM;
  localparam logic [1:0] Z = bdm_pkg::OffZ;
  localparam logic [1:0] P = bdm_pkg::OffP;

  logic [bdm_pkg::SampleW-1:0] gr0, gb0, gr_m0, gr_mp, gr_0p, gb_0m, gb_pm, gb_p0;
  logic [bdm_pkg::SampleW-1:0] g00, r00, b00, gbc, r_m0, r_mp, r_0p, b_0m, b_pm, b_p0;
  logic [bdm_pkg::PixW-1:0]    bp, bn, rp, rn;

  // green estimates around the centre
  assign gr0   = bdm_pkg::green_at_red(win_i, Z, Z);
  assign gb0   = bdm_pkg::green_at_blue(win_i, Z, Z);
  assign gr_m0 = bdm_pkg::green_at_red(win_i, M, Z);
  assign gr_mp = bdm_pkg::green_at_red(win_i, M, P);
  assign gr_0p = bdm_pkg::green_at_red(win_i, Z, P);
  assign gb_0m = bdm_pkg::green_at_blue(win_i, Z, M);
  assign gb_pm = bdm_pkg::green_at_blue(win_i, P, M);
  assign gb_p0 = bdm_pkg::green_at_blue(win_i, P, Z);

  assign g00  = win_i[Z][Z].gr;
  assign gbc  = win_i[Z][Z].gb;
  assign r00  = win_i[Z][Z].r;
  assign b00  = win_i[Z][Z].b;
  assign r_m0 = win_i[M][Z].r;
  assign r_mp = win_i[M][P].r;
  assign r_0p = win_i[Z][P].r;
  assign b_0m = win_i[Z][M].b;
  assign b_pm = win_i[P][M].b;
  assign b_p0 = win_i[P][Z].b;

  // diagonal candidates
  assign bp = bdm_pkg::corrected(gr0, gb0, gb_pm, b00, b_pm);
  assign bn = bdm_pkg::corrected(gr0, gb_p0, gb_0m, b_p0, b_0m);
  assign rp = bdm_pkg::corrected(gb0, gr0, gr_mp, r00, r_mp);
  assign rn = bdm_pkg::corrected(gb0, gr_m0, gr_0p, r_m0, r_0p);

  always_comb begin
    px_o[0].red   = bdm_pkg::corrected(g00, gr0, gr_m0, r_m0, r00);
    px_o[0].green = {1'b0, g00};
    px_o[0].blue  = bdm_pkg::corrected(g00, gb0, gb_0m, b00, b_0m);

    px_o[1].red   = {1'b0, r00};
    px_o[1].green = {1'b0, gr0};
    px_o[1].blue  = (bdm_pkg::absd(b00, b_pm) < bdm_pkg::absd(b_p0, b_0m)) ? bp : bn;

    px_o[2].red   = (bdm_pkg::absd(r00, r_mp) < bdm_pkg::absd(r_m0, r_0p)) ? rp : rn;
    px_o[2].green = {1'b0, gb0};
    px_o[2].blue  = {1'b0, b00};

    px_o[3].red   = bdm_pkg::corrected(gbc, gr0, gr_0p, r00, r_0p);
    px_o[3].green = {1'b0, gbc};
    px_o[3].blue  = bdm_pkg::corrected(gbc, gb0, gb_p0, b00, b_p0);
  end

endmodule

>>> rtl/core/bayer_demosaic_edge_directed.sv
// Top level of the edge-directed Bayer demosaic block.
//
// Input channel (in_valid_i/in_ready_o) takes one 2x2 Bayer quad per request
// in raster order; frame_start_i marks column 0, row 0 of a frame. The config
// channel (cfg_valid_i/cfg_ready_o) writes the image width in quads; it is
// always ready, and it must be written only while the block is idle; the
// block itself does not enforce this. The output channel
// (out_valid_o/out_ready_i) gives four RGB pixels per centred quad, order
// (0,0),(1,0),(0,1),(1,1), with last_of_quad_o on the fourth. Border quads
// (first or last column or row) give no pixels. An accepted quad passes the
// store stage, the window register and the output serialiser registers
// before out_valid_o rises. While pixels are produced, the quad rate is set
// by the output serialiser, which sends one pixel a cycle while out_ready_i
// is high; quads of column or row below 2 make no request and are taken
// every cycle unless the store stage is held. The line store is one
// 2048-entry memory with one read and one write port a cycle. Reset clears
// counters, window and pipeline valid flags; the line store is not cleared.
// A stalled receiver holds the current pixel; the pipeline fills (one quad in
// the store stage, one in the window stage) and then drops in_ready_o.
module bayer_demosaic_edge_directed (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bdm_pkg::CfgW-1:0]        cfg_quad_columns_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bdm_pkg::SampleW-1:0]     green_red_row_i,
  input  logic [bdm_pkg::SampleW-1:0]     red_sample_i,
  input  logic [bdm_pkg::SampleW-1:0]     blue_sample_i,
  input  logic [bdm_pkg::SampleW-1:0]     green_blue_row_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            pixel_dx_o,
  output logic                            pixel_dy_o,
  output logic [bdm_pkg::ColW-1:0]        quad_col_o,
  output logic [bdm_pkg::RowW-1:0]        quad_row_o,
  output logic signed [bdm_pkg::PixW-1:0] red_out_o,
  output logic signed [bdm_pkg::PixW-1:0] green_out_o,
  output logic signed [bdm_pkg::PixW-1:0] blue_out_o,
  output logic                            last_of_quad_o
);

  bdm_pkg::quad_t           quad;
  bdm_pkg::win_req_t        req;
  logic                     s2_ready;

  logic                     s2_valid_q;
  bdm_pkg::win_t            s2_win_q;
  logic [bdm_pkg::ColW-1:0] s2_col_q;
  logic [bdm_pkg::RowW-1:0] s2_row_q;

  bdm_pkg::pixel_t [3:0]    px;
  logic                     ob_valid_q;
  logic [1:0]               ob_idx_q;
  bdm_pkg::pixel_t [3:0]    ob_px_q;
  logic [bdm_pkg::ColW-1:0] ob_col_q;
  logic [bdm_pkg::RowW-1:0] ob_row_q;
  logic                     ob_last, ob_free, ob_load, out_take;

  assign quad = '{gr: green_red_row_i, r: red_sample_i, b: blue_sample_i, gb: green_blue_row_i};

  bdm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_quad_columns_i (cfg_quad_columns_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .quad_i             (quad),
    .frame_start_i      (frame_start_i),
    .req_o              (req),
    .req_ready_i        (s2_ready)
  );

  // output serialiser handshake
  assign ob_last  = (ob_idx_q == 2'd3);
  assign out_take = ob_valid_q && out_ready_i;
  assign ob_free  = !ob_valid_q || (out_ready_i && ob_last);
  assign ob_load  = s2_valid_q && ob_free;
  assign s2_ready = !s2_valid_q || ob_load;

  // hold the centred window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (req.valid && s2_ready) begin
      s2_valid_q <= 1'b1;
    end else if (ob_load) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && s2_ready) begin
      s2_win_q <= req.win;
      s2_col_q <= req.col;
      s2_row_q <= req.row;
    end
  end

  bdm_interp u_interp (
    .win_i (s2_win_q),
    .px_o  (px)
  );

  // load four pixels, then send one per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      ob_idx_q   <= 2'd0;
    end else if (ob_load) begin
      ob_valid_q <= 1'b1;
      ob_idx_q   <= 2'd0;
    end else if (out_take) begin
      if (ob_last) begin
        ob_valid_q <= 1'b0;
      end
      ob_idx_q <= ob_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_load) begin
      ob_px_q  <= px;
      ob_col_q <= s2_col_q;
      ob_row_q <= s2_row_q;
    end
  end

  assign out_valid_o    = ob_valid_q;
  assign pixel_dx_o     = ob_idx_q[0];
  assign pixel_dy_o     = ob_idx_q[1];
  assign quad_col_o     = ob_col_q;
  assign quad_row_o     = ob_row_q;
  assign red_out_o      = ob_px_q[ob_idx_q].red;
  assign green_out_o    = ob_px_q[ob_idx_q].green;
  assign blue_out_o     = ob_px_q[ob_idx_q].blue;
  assign last_of_quad_o = ob_last;

endmodule

>>> rtl/core/bdm_checker.sv
// Port-level checker of the demosaic block and its bind to the top level.
module bdm_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     pixel_dx_o,
  input logic                     pixel_dy_o,
  input logic [bdm_pkg::ColW-1:0] quad_col_o,
  input logic                     last_of_quad_o
);

  // no pixel while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("pixel shown during reset");

  // last flag only on the bottom-right pixel
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_quad_o == (pixel_dx_o && pixel_dy_o)))
    else $error("last_of_quad on wrong pixel");

  // the rest of a quad follows without a gap
  a_quad_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_quad_o) |=>
      (out_valid_o && $stable(quad_col_o)))
    else $error("quad run broken");

  // a new quad starts at the top-left pixel
  a_quad_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_quad_o) |=>
      (!out_valid_o || (!pixel_dx_o && !pixel_dy_o)))
    else $error("quad does not start at top-left");

  // a stalled pixel holds its position
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pixel_dx_o) && $stable(pixel_dy_o) && $stable(quad_col_o)))
    else $error("stalled pixel changed");

endmodule

bind bayer_demosaic_edge_directed bdm_checker u_bdm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_dx_o     (pixel_dx_o),
  .pixel_dy_o     (pixel_dy_o),
  .quad_col_o     (quad_col_o),
  .last_of_quad_o (last_of_quad_o)
);
